/* rtl/ps2wm_pkg.sv */
// shared types and constants for the ps2 wheel mouse packet tracker
package ps2wm_pkg;

  localparam int unsigned POS_WIDTH_DEF = 16;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned LIMIT_W       = 15;
  localparam int unsigned QUEUE_DEPTH   = 2;
  localparam int unsigned IN_DATA_W     = 48;
  localparam int unsigned OUT_DATA_W    = 72;
  localparam int unsigned OUT_USER_W    = 3;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;

  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_SET  = 1'b1;

  localparam logic [LIMIT_W-1:0] WIDTH_RESET  = 15'd1024;
  localparam logic [LIMIT_W-1:0] HEIGHT_RESET = 15'd768;

  localparam logic [1:0] LAST_SLOT = 2'd3;

  localparam logic [3:0] WHEEL_UP    = 4'h1;
  localparam logic [3:0] WHEEL_DOWN  = 4'hF;
  localparam logic [3:0] WHEEL_LEFT  = 4'hE;
  localparam logic [3:0] WHEEL_RIGHT = 4'h2;

  localparam logic [1:0] SCROLL_ZERO = 2'd0;
  localparam logic [1:0] SCROLL_POS  = 2'd1;
  localparam logic [1:0] SCROLL_NEG  = 2'd3;

  typedef enum logic [1:0] {
    CMD_SET,
    CMD_PARTIAL,
    CMD_DROP,
    CMD_PACKET
  } cmd_kind_t;

  // val_x/val_y: set position, or sign-extended 9-bit packet deltas
  typedef struct packed {
    cmd_kind_t   kind;
    logic [15:0] val_x;
    logic [15:0] val_y;
    logic [2:0]  btn;
    logic [1:0]  scr_x;
    logic [1:0]  scr_y;
  } cmd_t;

endpackage

/* rtl/ps2wm_front.sv */
// front end: collects mouse bytes into packets and classifies each transaction
module ps2wm_front
  import ps2wm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tuser,
  input  logic [7:0]  rx_byte,
  input  logic [15:0] set_x,
  input  logic [15:0] set_y,
  input  logic [2:0]  set_buttons,
  input  logic [1:0]  set_scroll_x,
  input  logic [1:0]  set_scroll_y,
  input  logic        q_ready,
  output logic        q_push,
  output cmd_t        q_cmd
);

  logic [1:0] byte_slot_r, byte_slot_nxt;
  logic [7:0] held_r [3];
  logic [7:0] status;

  assign q_push = in_tvalid && q_ready;
  assign status = held_r[0];

  always_comb begin
    byte_slot_nxt = byte_slot_r;
    q_cmd.kind    = CMD_PARTIAL;
    q_cmd.val_x   = set_x;
    q_cmd.val_y   = set_y;
    q_cmd.btn     = set_buttons;
    q_cmd.scr_x   = set_scroll_x;
    q_cmd.scr_y   = set_scroll_y;
    if (in_tuser == REQ_SET) begin
      q_cmd.kind = CMD_SET;
    end else if (byte_slot_r != LAST_SLOT) begin
      byte_slot_nxt = byte_slot_r + 2'd1;
    end else begin
      byte_slot_nxt = '0;
      q_cmd.val_x   = {{8{status[4]}}, held_r[1]};
      q_cmd.val_y   = {{8{status[5]}}, held_r[2]};
      q_cmd.btn     = status[2:0];
      q_cmd.scr_x   = SCROLL_ZERO;
      q_cmd.scr_y   = SCROLL_ZERO;
      unique case (rx_byte[3:0])
        WHEEL_UP:    q_cmd.scr_y = SCROLL_POS;
        WHEEL_DOWN:  q_cmd.scr_y = SCROLL_NEG;
        WHEEL_LEFT:  q_cmd.scr_x = SCROLL_NEG;
        WHEEL_RIGHT: q_cmd.scr_x = SCROLL_POS;
        default: ;
      endcase
      // either overflow bit throws the whole packet away
      q_cmd.kind = (status[7] || status[6]) ? CMD_DROP : CMD_PACKET;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_slot_r <= '0;
    end else if (q_push) begin
      byte_slot_r <= byte_slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push && in_tuser == REQ_BYTE && byte_slot_r != LAST_SLOT) begin
      held_r[byte_slot_r] <= rx_byte;
    end
  end

endmodule

/* rtl/ps2wm_fifo.sv */
// two-entry command queue between front and back
module ps2wm_fifo
  import ps2wm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic not_full,
  input  logic pop,
  output logic not_empty,
  output cmd_t pop_cmd
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign not_full  = (count_r != CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_cmd   = entry_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* rtl/ps2wm_back.sv */
// back end: applies commands to cursor state and holds the result register
module ps2wm_back
  import ps2wm_pkg::*;
#(
  parameter int unsigned PosWidth = POS_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LIMIT_W-1:0]   cfg_data,
  input  logic                 q_valid,
  input  cmd_t                 q_cmd,
  output logic                 q_pop,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [15:0]          cursor_x,
  output logic [15:0]          cursor_y,
  output logic [2:0]           buttons,
  output logic [1:0]           scroll_x,
  output logic [1:0]           scroll_y,
  output logic [31:0]          change_count,
  output logic [2:0]           flags
);

  localparam int unsigned CW = ((PosWidth > 16) ? PosWidth : 16) + 1;

  logic [LIMIT_W-1:0]  width_r, height_r;
  logic [PosWidth-1:0] pos_x_r, pos_x_nxt, pos_y_r, pos_y_nxt;
  logic [2:0]          btn_r, btn_nxt;
  logic [1:0]          scr_x_r, scr_x_nxt, scr_y_r, scr_y_nxt;
  logic [31:0]         count_r, count_nxt;
  logic                valid_r;
  logic                done_r, done_nxt;
  logic                drop_r, drop_nxt;
  logic                chg_r, chg_nxt;

  logic signed [CW-1:0] px_ext, py_ext, dlt_x, dlt_y, sum_x, sum_y;
  logic signed [CW-1:0] lim_x, lim_y, clamp_x, clamp_y;
  logic        [CW-1:0] out_x_ext, out_y_ext;

  assign q_pop = q_valid && (!valid_r || out_tready);

  assign px_ext = CW'($signed(pos_x_r));
  assign py_ext = CW'($signed(pos_y_r));
  assign dlt_x  = CW'($signed(q_cmd.val_x));
  assign dlt_y  = CW'($signed(q_cmd.val_y));
  assign sum_x  = px_ext + dlt_x;
  assign sum_y  = py_ext - dlt_y;
  assign lim_x  = CW'({1'b0, width_r});
  assign lim_y  = CW'({1'b0, height_r});

  always_comb begin
    clamp_x = sum_x;
    if (sum_x < 0) begin
      clamp_x = '0;
    end else if (sum_x > lim_x) begin
      clamp_x = lim_x;
    end
    clamp_y = sum_y;
    if (sum_y < 0) begin
      clamp_y = '0;
    end else if (sum_y > lim_y) begin
      clamp_y = lim_y;
    end
  end

  always_comb begin
    pos_x_nxt = pos_x_r;
    pos_y_nxt = pos_y_r;
    btn_nxt   = btn_r;
    scr_x_nxt = scr_x_r;
    scr_y_nxt = scr_y_r;
    count_nxt = count_r;
    done_nxt  = 1'b0;
    drop_nxt  = 1'b0;
    chg_nxt   = 1'b0;
    unique case (q_cmd.kind)
      CMD_SET: begin
        pos_x_nxt = dlt_x[PosWidth-1:0];
        pos_y_nxt = dlt_y[PosWidth-1:0];
        btn_nxt   = q_cmd.btn;
        scr_x_nxt = q_cmd.scr_x;
        scr_y_nxt = q_cmd.scr_y;
      end
      CMD_PARTIAL: ;
      CMD_DROP: begin
        done_nxt = 1'b1;
        drop_nxt = 1'b1;
      end
      CMD_PACKET: begin
        done_nxt  = 1'b1;
        pos_x_nxt = clamp_x[PosWidth-1:0];
        pos_y_nxt = clamp_y[PosWidth-1:0];
        btn_nxt   = q_cmd.btn;
        scr_x_nxt = q_cmd.scr_x;
        scr_y_nxt = q_cmd.scr_y;
        chg_nxt   = (pos_x_nxt != pos_x_r) || (pos_y_nxt != pos_y_r) ||
                    (btn_nxt != btn_r) || (q_cmd.scr_x != SCROLL_ZERO) ||
                    (q_cmd.scr_y != SCROLL_ZERO);
        if (chg_nxt) begin
          count_nxt = count_r + 32'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
      pos_x_r  <= '0;
      pos_y_r  <= '0;
      btn_r    <= '0;
      scr_x_r  <= '0;
      scr_y_r  <= '0;
      count_r  <= '0;
      valid_r  <= 1'b0;
      done_r   <= 1'b0;
      drop_r   <= 1'b0;
      chg_r    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_index == REG_SCREEN_WIDTH) begin
        width_r <= cfg_data;
      end
      if (cfg_valid && cfg_index == REG_SCREEN_HEIGHT) begin
        height_r <= cfg_data;
      end
      if (q_pop) begin
        pos_x_r <= pos_x_nxt;
        pos_y_r <= pos_y_nxt;
        btn_r   <= btn_nxt;
        scr_x_r <= scr_x_nxt;
        scr_y_r <= scr_y_nxt;
        count_r <= count_nxt;
        done_r  <= done_nxt;
        drop_r  <= drop_nxt;
        chg_r   <= chg_nxt;
        valid_r <= 1'b1;
      end else if (out_tready) begin
        valid_r <= 1'b0;
      end
    end
  end

  // the result is the state after the step, so the state registers drive it
  assign out_x_ext    = CW'(pos_x_r);
  assign out_y_ext    = CW'(pos_y_r);
  assign cursor_x     = out_x_ext[15:0];
  assign cursor_y     = out_y_ext[15:0];
  assign buttons      = btn_r;
  assign scroll_x     = scr_x_r;
  assign scroll_y     = scr_y_r;
  assign change_count = count_r;
  assign flags        = {chg_r, drop_r, done_r};
  assign out_tvalid   = valid_r;

endmodule

/* rtl/ps2_wheel_mouse_packet_tracker_unit.sv */
// top level of the ps2 wheel mouse packet tracker
//
// in_*: one transaction per mouse byte (in_tuser = 0) or per direct cursor
//   load (in_tuser = 1). Bytes are gathered into 4-byte packets; a packet
//   with an overflow bit set is dropped, otherwise it moves the cursor by
//   the signed deltas, clamps each axis to 0..limit and latches buttons
//   and decoded wheel scroll.
// out_*: exactly one result transaction per input transaction, carrying
//   the cursor state after that step and the done/dropped/changed flags.
// cfg_*: writes the x and y limits; always ready. The user must write them only
//   while idle; the block itself does not enforce this.
// Path: each command passes the queue, then the result register, which drives out_tvalid.
// Throughput: one transaction per cycle while out_tready is high; the front queue
//   and the result register each take one item per clock.
// Reset: byte position returns to the start of a packet, cursor, buttons,
//   scroll and change count clear, limits return to 1024 and 768.
// Stall: while out_tready is low the result holds and up to two more
//   transactions are queued; after that in_tready drops.
module ps2_wheel_mouse_packet_tracker_unit
  import ps2wm_pkg::*;
#(
  parameter int unsigned PosWidth = POS_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // rx_byte, set_x, set_y, set_buttons, set_scroll_x, set_scroll_y
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // req_type
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // cursor_x, cursor_y, buttons, scroll_x, scroll_y, change_count
  output logic [OUT_DATA_W-1:0] out_tdata,
  // packet_done, packet_dropped, state_changed
  output logic [OUT_USER_W-1:0] out_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [LIMIT_W-1:0]    cfg_data
);

  logic        q_push, q_not_full, q_pop, q_not_empty;
  cmd_t        push_cmd, pop_cmd;
  logic [15:0] cursor_x, cursor_y;
  logic [2:0]  buttons;
  logic [1:0]  scroll_x, scroll_y;
  logic [31:0] change_count;

  assign in_tready = q_not_full;
  assign cfg_ready = 1'b1;

  ps2wm_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tuser     (in_tuser),
    .rx_byte      (in_tdata[7:0]),
    .set_x        (in_tdata[23:8]),
    .set_y        (in_tdata[39:24]),
    .set_buttons  (in_tdata[42:40]),
    .set_scroll_x (in_tdata[44:43]),
    .set_scroll_y (in_tdata[46:45]),
    .q_ready      (q_not_full),
    .q_push       (q_push),
    .q_cmd        (push_cmd)
  );

  ps2wm_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_cmd   (pop_cmd)
  );

  ps2wm_back #(
    .PosWidth (PosWidth)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .q_valid      (q_not_empty),
    .q_cmd        (pop_cmd),
    .q_pop        (q_pop),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .cursor_x     (cursor_x),
    .cursor_y     (cursor_y),
    .buttons      (buttons),
    .scroll_x     (scroll_x),
    .scroll_y     (scroll_y),
    .change_count (change_count),
    .flags        (out_tuser)
  );

  assign out_tdata = {1'b0, change_count, scroll_y, scroll_x, buttons, cursor_y, cursor_x};

`ifndef SYNTHESIS
  // a full queue only happens behind a waiting result
  a_full_needs_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("queue full with no pending result");

  a_drop_is_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tuser[0])
    else $error("dropped packet not marked done");

  a_change_is_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tuser[0] && !out_tuser[1])
    else $error("state change flagged on a non-applied packet");

  // the counter only moves on a popped packet
  a_count_moves_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
    !q_pop |=> $stable(change_count))
    else $error("change count moved without a command");
`endif

endmodule

/* bench/tb_ps2_wheel_mouse_packet_tracker_unit.sv */
// testbench for the ps2 wheel mouse packet tracker: directed table, then random packets
module tb_ps2_wheel_mouse_packet_tracker_unit
  import ps2wm_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int   IDLE_LIMIT = 2000;
  localparam int   NUM_PHASES = 6;
  localparam int   PHASE_ITEMS = 230;

  typedef struct packed {
    logic        req;
    logic [7:0]  rx;
    logic [15:0] sx;
    logic [15:0] sy;
    logic [2:0]  sb;
    logic [1:0]  ssx;
    logic [1:0]  ssy;
  } mouse_req_t;

  typedef struct packed {
    logic [15:0] cur_x;
    logic [15:0] cur_y;
    logic [2:0]  btn;
    logic [1:0]  scr_x;
    logic [1:0]  scr_y;
    logic [31:0] count;
    logic        done;
    logic        dropped;
    logic        changed;
  } cursor_report_t;

  typedef struct packed {
    mouse_req_t     rq;
    logic           typed;
    cursor_report_t want;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [LIMIT_W-1:0]    cfg_data;

  ps2_wheel_mouse_packet_tracker_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  // tracker state as the block should hold it
  logic [1:0]         trk_slot;
  logic [7:0]         trk_held [0:2];
  logic [15:0]        trk_x;
  logic [15:0]        trk_y;
  logic [2:0]         trk_btn;
  logic [1:0]         trk_wx;
  logic [1:0]         trk_wy;
  logic [31:0]        trk_count;
  logic [LIMIT_W-1:0] trk_wlim;
  logic [LIMIT_W-1:0] trk_hlim;

  cursor_report_t pending_reports[$];
  plan_row_t      plan_q[$];
  int             fail_count = 0;
  int             results_seen = 0;
  int             burst_left = 0;

  function automatic cursor_report_t advance_cursor(mouse_req_t rq);
    cursor_report_t r;
    logic [7:0]     st;
    int             nx;
    int             ny;
    int             dxv;
    int             dyv;
    logic [15:0]    ox;
    logic [15:0]    oy;
    logic [2:0]     ob;
    logic [1:0]     wx;
    logic [1:0]     wy;
    r = '0;
    if (rq.req == REQ_SET) begin
      trk_x   = rq.sx;
      trk_y   = rq.sy;
      trk_btn = rq.sb;
      trk_wx  = rq.ssx;
      trk_wy  = rq.ssy;
    end else if (trk_slot != LAST_SLOT) begin
      trk_held[trk_slot] = rq.rx;
      trk_slot = trk_slot + 2'd1;
    end else begin
      st = trk_held[0];
      trk_slot = '0;
      r.done = 1'b1;
      if (st[7] || st[6]) begin
        r.dropped = 1'b1;
      end else begin
        ox = trk_x;
        oy = trk_y;
        ob = trk_btn;
        // 9-bit deltas: sign bits live in the status byte
        dxv = st[4] ? int'(trk_held[1]) - 256 : int'(trk_held[1]);
        dyv = st[5] ? int'(trk_held[2]) - 256 : int'(trk_held[2]);
        nx = int'($signed(trk_x)) + dxv;
        ny = int'($signed(trk_y)) - dyv;
        if (nx < 0) nx = 0;
        if (nx > int'(trk_wlim)) nx = int'(trk_wlim);
        if (ny < 0) ny = 0;
        if (ny > int'(trk_hlim)) ny = int'(trk_hlim);
        wx = SCROLL_ZERO;
        wy = SCROLL_ZERO;
        case (rq.rx[3:0])
          WHEEL_UP:    wy = SCROLL_POS;
          WHEEL_DOWN:  wy = SCROLL_NEG;
          WHEEL_LEFT:  wx = SCROLL_NEG;
          WHEEL_RIGHT: wx = SCROLL_POS;
          default: ;
        endcase
        trk_x   = nx[15:0];
        trk_y   = ny[15:0];
        trk_btn = st[2:0];
        trk_wx  = wx;
        trk_wy  = wy;
        if (trk_x != ox || trk_y != oy || trk_btn != ob ||
            wx != SCROLL_ZERO || wy != SCROLL_ZERO) begin
          r.changed = 1'b1;
          trk_count = trk_count + 32'd1;
        end
      end
    end
    r.cur_x = trk_x;
    r.cur_y = trk_y;
    r.btn   = trk_btn;
    r.scr_x = trk_wx;
    r.scr_y = trk_wy;
    r.count = trk_count;
    return r;
  endfunction

  function automatic mouse_req_t byte_req(logic [7:0] b);
    mouse_req_t rq;
    rq = '0;
    rq.req = REQ_BYTE;
    rq.rx = b;
    return rq;
  endfunction

  function automatic mouse_req_t set_req(logic [15:0] x, logic [15:0] y, logic [2:0] b,
                                         logic [1:0] wx, logic [1:0] wy);
    mouse_req_t rq;
    rq = '0;
    rq.req = REQ_SET;
    rq.sx = x;
    rq.sy = y;
    rq.sb = b;
    rq.ssx = wx;
    rq.ssy = wy;
    return rq;
  endfunction

  function automatic cursor_report_t report(logic [15:0] x, logic [15:0] y, logic [2:0] b,
                                            logic [1:0] wx, logic [1:0] wy,
                                            logic [31:0] cnt, logic dn, logic dr);
    cursor_report_t r;
    r = '0;
    r.cur_x = x;
    r.cur_y = y;
    r.btn = b;
    r.scr_x = wx;
    r.scr_y = wy;
    r.count = cnt;
    r.done = dn;
    r.dropped = dr;
    return r;
  endfunction

  function automatic logic [15:0] pick_pos(logic [LIMIT_W-1:0] lim);
    int unsigned r;
    logic [15:0] p;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      p = 16'($urandom_range(0, int'(lim)));
    end else if (r < 75) begin
      p = 16'($urandom);
    end else begin
      case ($urandom_range(0, 3))
        0: p = 16'h8000;
        1: p = 16'h7FFF;
        2: p = 16'h0000;
        default: p = {1'b0, lim};
      endcase
    end
    return p;
  endfunction

  function automatic logic [7:0] pick_delta();
    if ($urandom_range(0, 99) < 40)
      return $urandom_range(0, 1) ? 8'($urandom_range(0, 6)) : 8'($urandom_range(250, 255));
    return 8'($urandom);
  endfunction

  // mostly well-formed packets, some noise bytes and mid-packet cursor loads
  function automatic mouse_req_t random_req();
    mouse_req_t  rq;
    int unsigned r;
    logic [7:0]  b;
    rq.req = REQ_BYTE;
    rq.rx  = 8'($urandom);
    rq.sx  = 16'($urandom);
    rq.sy  = 16'($urandom);
    rq.sb  = 3'($urandom);
    rq.ssx = 2'($urandom);
    rq.ssy = 2'($urandom);
    r = $urandom_range(0, 99);
    if (r < 8) begin
      rq.req = REQ_SET;
      rq.sx = pick_pos(trk_wlim);
      rq.sy = pick_pos(trk_hlim);
    end else if (r >= 14) begin
      b = 8'($urandom);
      case (trk_slot)
        2'd0: begin
          if ($urandom_range(0, 99) < 12) begin
            if (b[7:6] == 2'b00) b[6 + $urandom_range(0, 1)] = 1'b1;
          end else begin
            b[7:6] = 2'b00;
            b[3] = 1'b1;
          end
        end
        LAST_SLOT: begin
          case ($urandom_range(0, 5))
            0: b[3:0] = WHEEL_UP;
            1: b[3:0] = WHEEL_DOWN;
            2: b[3:0] = WHEEL_LEFT;
            3: b[3:0] = WHEEL_RIGHT;
            4: b[3:0] = 4'h0;
            default: ;
          endcase
        end
        default: b = pick_delta();
      endcase
      rq.rx = b;
    end
    return rq;
  endfunction

  function automatic int pick_gap();
    int unsigned r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 8);
    return $urandom_range(15, 40);
  endfunction

  task automatic send_req(input mouse_req_t rq, input logic typed, input cursor_report_t want);
    cursor_report_t pred;
    int             g;
    in_tvalid <= 1'b1;
    in_tuser  <= rq.req;
    in_tdata  <= {1'b0, rq.ssy, rq.ssx, rq.sb, rq.sy, rq.sx, rq.rx};
    do @(posedge clk); while (!in_tready);
    pred = advance_cursor(rq);
    pending_reports.push_back(typed ? want : pred);
    g = pick_gap();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    // let the queue and result register empty, plus margin
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [LIMIT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_SCREEN_WIDTH) trk_wlim = val;
    else trk_hlim = val;
    @(posedge clk);
  endtask

  // result side: random ready with a couple of long hold-offs
  initial begin : consumer
    int   n;
    logic v;
    int   next_hold;
    int unsigned r;
    next_hold = 300;
    @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (results_seen >= next_hold) begin
        v = 1'b0;
        n = 80;
        next_hold += 500;
      end else if (r < 60) begin
        v = 1'b1;
        n = 1;
      end else if (r < 85) begin
        v = 1'b1;
        n = $urandom_range(5, 40);
      end else if (r < 97) begin
        v = 1'b0;
        n = $urandom_range(1, 3);
      end else begin
        v = 1'b0;
        n = $urandom_range(10, 30);
      end
      out_tready <= v;
      repeat (n) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    cursor_report_t got;
    cursor_report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      got.cur_x   = out_tdata[15:0];
      got.cur_y   = out_tdata[31:16];
      got.btn     = out_tdata[34:32];
      got.scr_x   = out_tdata[36:35];
      got.scr_y   = out_tdata[38:37];
      got.count   = out_tdata[70:39];
      got.done    = out_tuser[0];
      got.dropped = out_tuser[1];
      got.changed = out_tuser[2];
      if (pending_reports.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result transaction %0d: x=%h y=%h", results_seen,
                   got.cur_x, got.cur_y);
      end else begin
        want = pending_reports.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("mismatch at result %0d", results_seen);
            $display("  exp x=%h y=%h btn=%h scr=%h/%h cnt=%h done=%b drop=%b chg=%b",
                     want.cur_x, want.cur_y, want.btn, want.scr_x, want.scr_y,
                     want.count, want.done, want.dropped, want.changed);
            $display("  got x=%h y=%h btn=%h scr=%h/%h cnt=%h done=%b drop=%b chg=%b",
                     got.cur_x, got.cur_y, got.btn, got.scr_x, got.scr_y,
                     got.count, got.done, got.dropped, got.changed);
          end
        end
      end
    end
  end

  // ends the run if no transaction of any kind completes for too long
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [LIMIT_W-1:0] w_set [NUM_PHASES];
    logic [LIMIT_W-1:0] h_set [NUM_PHASES];
    cursor_report_t     loaded;
    cursor_report_t     loaded_drop;
    plan_row_t          row;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = 1'b0;
    out_tready = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    trk_slot   = '0;
    trk_held   = '{default: '0};
    trk_x      = '0;
    trk_y      = '0;
    trk_btn    = '0;
    trk_wx     = '0;
    trk_wy     = '0;
    trk_count  = '0;
    trk_wlim   = WIDTH_RESET;
    trk_hlim   = HEIGHT_RESET;

    w_set = '{15'd0, 15'd32767, 15'd640, 15'($urandom), 15'd32767, WIDTH_RESET};
    h_set = '{15'd0, 15'd32767, 15'd480, 15'($urandom), 15'd0, HEIGHT_RESET};

    // load the cursor at its extremes, then an overflow packet must leave it alone
    loaded      = report(16'h8000, 16'h7FFF, 3'd7, 2'd3, 2'd2, 32'd0, 1'b0, 1'b0);
    loaded_drop = report(16'h8000, 16'h7FFF, 3'd7, 2'd3, 2'd2, 32'd0, 1'b1, 1'b1);
    plan_q.push_back('{set_req(16'h8000, 16'h7FFF, 3'd7, 2'd3, 2'd2), 1'b1, loaded});
    plan_q.push_back('{byte_req(8'h80), 1'b1, loaded});
    plan_q.push_back('{byte_req(8'h12), 1'b1, loaded});
    plan_q.push_back('{byte_req(8'h34), 1'b1, loaded});
    plan_q.push_back('{byte_req(8'h0F), 1'b1, loaded_drop});
    // negative cursor, both deltas -256, wheel up
    plan_q.push_back('{byte_req(8'h39), 1'b0, '0});
    plan_q.push_back('{byte_req(8'h00), 1'b0, '0});
    plan_q.push_back('{byte_req(8'h00), 1'b0, '0});
    plan_q.push_back('{byte_req(8'hF1), 1'b0, '0});
    // largest positive deltas, wheel left
    plan_q.push_back('{byte_req(8'h0E), 1'b0, '0});
    plan_q.push_back('{byte_req(8'hFF), 1'b0, '0});
    plan_q.push_back('{byte_req(8'hFF), 1'b0, '0});
    plan_q.push_back('{byte_req(8'h0E), 1'b0, '0});
    // nothing moves, no scroll: not counted
    plan_q.push_back('{byte_req(8'h0E), 1'b0, '0});
    plan_q.push_back('{byte_req(8'h00), 1'b0, '0});
    plan_q.push_back('{byte_req(8'h00), 1'b0, '0});
    plan_q.push_back('{byte_req(8'h30), 1'b0, '0});
    // wheel right, buttons released
    plan_q.push_back('{byte_req(8'h08), 1'b0, '0});
    plan_q.push_back('{byte_req(8'h00), 1'b0, '0});
    plan_q.push_back('{byte_req(8'h00), 1'b0, '0});
    plan_q.push_back('{byte_req(8'h02), 1'b0, '0});
    // y past the top limit, wheel down
    plan_q.push_back('{byte_req(8'h28), 1'b0, '0});
    plan_q.push_back('{byte_req(8'h01), 1'b0, '0});
    plan_q.push_back('{byte_req(8'h00), 1'b0, '0});
    plan_q.push_back('{byte_req(8'h0F), 1'b0, '0});

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan_q[i]) begin
      row = plan_q[i];
      send_req(row.rq, row.typed, row.want);
    end
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      cfg_write(REG_SCREEN_WIDTH, w_set[p]);
      cfg_write(REG_SCREEN_HEIGHT, h_set[p]);
      repeat (PHASE_ITEMS) send_req(random_req(), 1'b0, '0);
      drain();
    end

    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending_reports.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
